// ===== sv/sorted_range_prime_counter_defines.svh =====
// assertion macros for the sorted range prime counter
`ifndef SORTED_RANGE_PRIME_COUNTER_DEFINES_SVH
`define SORTED_RANGE_PRIME_COUNTER_DEFINES_SVH

// property that must hold when not in reset
`define SRPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property that must hold on every clock, reset included
`define SRPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/srpc_pkg.sv =====
package srpc_pkg;

   localparam int unsigned STORE_DEPTH_DEFAULT = 1024;
   localparam int unsigned VALUE_LIMIT_DEFAULT = 65536;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // back end sequencer states
   typedef enum logic [3:0] {
      BE_SIEVE_INIT,
      BE_SIEVE_OUTER,
      BE_SIEVE_CHECK,
      BE_SIEVE_INNER,
      BE_IDLE,
      BE_SRCH_RD,
      BE_SRCH_CMP,
      BE_CHK_RD,
      BE_CHK_CMP,
      BE_WALK_RD,
      BE_WALK_PRM,
      BE_WALK_CMP,
      BE_OUT
   } be_state_type;

   // one queued transaction from the front part to the back part
   typedef struct packed {
      logic               query;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] range_low;
      logic [VALUE_W-1:0] range_high;
   } item_type;

endpackage

// ===== sv/srpc_ram.sv =====
module srpc_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/srpc_front.sv =====
module srpc_front #(
   parameter int unsigned QUEUE_DEPTH = srpc_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [srpc_pkg::VALUE_W-1:0]   req_value,
   input  logic [srpc_pkg::VALUE_W-1:0]   req_range_low,
   input  logic [srpc_pkg::VALUE_W-1:0]   req_range_high,
   output logic                           q_valid,
   output srpc_pkg::item_type             q_item,
   input  logic                           q_pop
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   srpc_pkg::item_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             push;

   assign req_stall = (fill_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // classify and store the transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].query      <= (req_command == srpc_pkg::CMD_QUERY);
         slot_ff[wr_ptr_ff].value      <= req_value;
         slot_ff[wr_ptr_ff].range_low  <= req_range_low;
         slot_ff[wr_ptr_ff].range_high <= req_range_high;
      end
   end

endmodule

// ===== sv/srpc_back.sv =====
module srpc_back #(
   parameter int unsigned STORE_DEPTH = 1024,
   parameter int unsigned VALUE_LIMIT = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  srpc_pkg::item_type             q_item,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [srpc_pkg::COUNT_W-1:0]   rsp_prime_count,
   output logic                           rsp_bounds_found,
   output logic                           sieve_busy
);

   localparam int unsigned AW  = $clog2(STORE_DEPTH);
   localparam int unsigned CW  = AW + 1;
   localparam int unsigned MW  = $clog2(VALUE_LIMIT);
   localparam int unsigned VW  = srpc_pkg::VALUE_W;
   localparam int unsigned MCW = MW + 1;

   srpc_pkg::be_state_type state_ff, state_in;

   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]  b_ff, b_in, j_ff, j_in;
   logic           second_ff, second_in;
   logic           found_ff, found_in;
   logic [srpc_pkg::COUNT_W-1:0] pc_ff, pc_in;
   logic [MCW-1:0] si_ff, si_in, sj_ff, sj_in;
   logic [VW-1:0]  walk_val_ff, walk_val_in;
   logic [VW-1:0]  item_low_ff, item_low_in, item_high_ff, item_high_in;

   logic [CW-1:0]  mid;
   logic [VW-1:0]  target;
   logic [AW-1:0]  st_rd_addr, st_wr_addr;
   logic [VW-1:0]  st_rd_data;
   logic           st_wr_en;
   logic [MW-1:0]  pm_rd_addr, pm_wr_addr;
   logic           pm_wr_en, pm_wr_data, pm_rd_data;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign target = second_ff ? item_high_ff : item_low_ff;

   // value store
   srpc_ram #(.WIDTH(VW), .DEPTH(STORE_DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_data(q_item.value),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd_data)
   );

   // prime bitmap, one means not prime (zero, one or composite)
   srpc_ram #(.WIDTH(1), .DEPTH(VALUE_LIMIT)) u_map (
      .clock  (clock),
      .wr_en  (pm_wr_en),
      .wr_addr(pm_wr_addr),
      .wr_data(pm_wr_data),
      .rd_addr(pm_rd_addr),
      .rd_data(pm_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srpc_pkg::BE_SIEVE_INIT: begin
            if (si_ff == MCW'(VALUE_LIMIT - 1)) state_in = srpc_pkg::BE_SIEVE_OUTER;
         end
         srpc_pkg::BE_SIEVE_OUTER: begin
            if ((2*MCW)'(si_ff) * (2*MCW)'(si_ff) >= (2*MCW)'(VALUE_LIMIT)) begin
               state_in = srpc_pkg::BE_IDLE;
            end else begin
               state_in = srpc_pkg::BE_SIEVE_CHECK;
            end
         end
         srpc_pkg::BE_SIEVE_CHECK: begin
            state_in = pm_rd_data ? srpc_pkg::BE_SIEVE_OUTER : srpc_pkg::BE_SIEVE_INNER;
         end
         srpc_pkg::BE_SIEVE_INNER: begin
            if (sj_ff + si_ff >= MCW'(VALUE_LIMIT)) state_in = srpc_pkg::BE_SIEVE_OUTER;
         end
         srpc_pkg::BE_IDLE: begin
            if (q_valid && q_item.query) state_in = srpc_pkg::BE_SRCH_RD;
         end
         srpc_pkg::BE_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               state_in = srpc_pkg::BE_SRCH_CMP;
            end else if (lo_ff >= count_ff) begin
               state_in = srpc_pkg::BE_OUT;
            end else begin
               state_in = srpc_pkg::BE_CHK_RD;
            end
         end
         srpc_pkg::BE_SRCH_CMP: state_in = srpc_pkg::BE_SRCH_RD;
         srpc_pkg::BE_CHK_RD:   state_in = srpc_pkg::BE_CHK_CMP;
         srpc_pkg::BE_CHK_CMP: begin
            if (st_rd_data != target) begin
               state_in = srpc_pkg::BE_OUT;
            end else if (second_ff) begin
               state_in = srpc_pkg::BE_WALK_RD;
            end else begin
               state_in = srpc_pkg::BE_SRCH_RD;
            end
         end
         srpc_pkg::BE_WALK_RD: begin
            state_in = (j_ff < count_ff) ? srpc_pkg::BE_WALK_PRM : srpc_pkg::BE_OUT;
         end
         srpc_pkg::BE_WALK_PRM: begin
            state_in = (st_rd_data > item_high_ff) ? srpc_pkg::BE_OUT
                                                    : srpc_pkg::BE_WALK_CMP;
         end
         srpc_pkg::BE_WALK_CMP: state_in = srpc_pkg::BE_WALK_RD;
         srpc_pkg::BE_OUT: begin
            if (!rsp_stall) state_in = srpc_pkg::BE_IDLE;
         end
         default: state_in = srpc_pkg::BE_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      b_in         = b_ff;
      j_in         = j_ff;
      second_in    = second_ff;
      found_in     = found_ff;
      pc_in        = pc_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      walk_val_in  = walk_val_ff;
      item_low_in  = item_low_ff;
      item_high_in = item_high_ff;
      q_pop        = 1'b0;
      st_wr_en     = 1'b0;
      st_wr_addr   = count_ff[AW-1:0];
      st_rd_addr   = mid[AW-1:0];
      pm_wr_en     = 1'b0;
      pm_wr_addr   = sj_ff[MW-1:0];
      pm_wr_data   = 1'b1;
      pm_rd_addr   = si_ff[MW-1:0];
      rsp_valid    = 1'b0;
      unique case (state_ff)
         srpc_pkg::BE_SIEVE_INIT: begin
            pm_wr_en   = 1'b1;
            pm_wr_addr = si_ff[MW-1:0];
            pm_wr_data = (si_ff < MCW'(2));
            si_in      = (si_ff == MCW'(VALUE_LIMIT - 1)) ? MCW'(2) : si_ff + 1'b1;
         end
         srpc_pkg::BE_SIEVE_OUTER: begin
            sj_in = MCW'((2*MCW)'(si_ff) * (2*MCW)'(si_ff));
         end
         srpc_pkg::BE_SIEVE_CHECK: begin
            if (pm_rd_data) si_in = si_ff + 1'b1;
         end
         srpc_pkg::BE_SIEVE_INNER: begin
            pm_wr_en = 1'b1;
            sj_in    = sj_ff + si_ff;
            if (sj_ff + si_ff >= MCW'(VALUE_LIMIT)) si_in = si_ff + 1'b1;
         end
         srpc_pkg::BE_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.query) begin
                  item_low_in  = q_item.range_low;
                  item_high_in = q_item.range_high;
                  lo_in        = '0;
                  hi_in        = count_ff;
                  second_in    = 1'b0;
                  found_in     = 1'b0;
                  pc_in        = '0;
               end else if (count_ff < CW'(STORE_DEPTH)) begin
                  st_wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         srpc_pkg::BE_SRCH_RD: begin
            st_rd_addr = (lo_ff < hi_ff) ? mid[AW-1:0] : lo_ff[AW-1:0];
         end
         srpc_pkg::BE_SRCH_CMP: begin
            if (st_rd_data < target) lo_in = mid + 1'b1;
            else hi_in = mid;
         end
         srpc_pkg::BE_CHK_RD: begin
            st_rd_addr = lo_ff[AW-1:0];
         end
         srpc_pkg::BE_CHK_CMP: begin
            if (st_rd_data == target) begin
               if (second_ff) begin
                  found_in = 1'b1;
                  j_in     = b_ff;
               end else begin
                  b_in      = lo_ff;
                  second_in = 1'b1;
                  lo_in     = '0;
                  hi_in     = count_ff;
               end
            end
         end
         srpc_pkg::BE_WALK_RD: begin
            st_rd_addr = j_ff[AW-1:0];
         end
         srpc_pkg::BE_WALK_PRM: begin
            walk_val_in = st_rd_data;
            pm_rd_addr  = MW'(st_rd_data);
         end
         srpc_pkg::BE_WALK_CMP: begin
            if (!pm_rd_data && (32'(walk_val_ff) < VALUE_LIMIT)) pc_in = pc_ff + 1'b1;
            j_in = j_ff + 1'b1;
         end
         srpc_pkg::BE_OUT: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srpc_pkg::BE_SIEVE_INIT;
         count_ff <= '0;
         si_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         si_ff    <= si_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      b_ff         <= b_in;
      j_ff         <= j_in;
      second_ff    <= second_in;
      found_ff     <= found_in;
      pc_ff        <= pc_in;
      sj_ff        <= sj_in;
      walk_val_ff  <= walk_val_in;
      item_low_ff  <= item_low_in;
      item_high_ff <= item_high_in;
   end

   assign rsp_prime_count  = pc_ff;
   assign rsp_bounds_found = found_ff;
   assign sieve_busy = (state_ff == srpc_pkg::BE_SIEVE_INIT) ||
                       (state_ff == srpc_pkg::BE_SIEVE_OUTER) ||
                       (state_ff == srpc_pkg::BE_SIEVE_CHECK) ||
                       (state_ff == srpc_pkg::BE_SIEVE_INNER);

endmodule

// ===== sv/sorted_range_prime_counter.sv =====
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_command, req_value, req_range_low/high
// rsp     | out       | rsp_valid, rsp_stall, rsp_prime_count, rsp_bounds_found
//
// a load is written to the value store; a query searches for its bounds, then walks
// the entries between them, paced by the single read port of the value store and the prime bitmap
// after reset the sieve runs over the bitmap in the back end, first initialising every
// entry and then crossing off multiples; transactions queue meanwhile
// the two-entry queue stalls req when full; a pending response holds under rsp_stall
`include "sorted_range_prime_counter_defines.svh"

module sorted_range_prime_counter #(
   parameter int unsigned STORE_DEPTH = srpc_pkg::STORE_DEPTH_DEFAULT,
   parameter int unsigned VALUE_LIMIT = srpc_pkg::VALUE_LIMIT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [srpc_pkg::VALUE_W-1:0]   req_value,
   input  logic [srpc_pkg::VALUE_W-1:0]   req_range_low,
   input  logic [srpc_pkg::VALUE_W-1:0]   req_range_high,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [srpc_pkg::COUNT_W-1:0]   rsp_prime_count,
   output logic                           rsp_bounds_found
);

   logic               q_valid, q_pop, sieve_busy;
   srpc_pkg::item_type q_item;

   // front part: accept and queue
   srpc_front #(.QUEUE_DEPTH(srpc_pkg::QUEUE_DEPTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_value     (req_value),
      .req_range_low (req_range_low),
      .req_range_high(req_range_high),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // back part: sieve, store, search and count
   srpc_back #(.STORE_DEPTH(STORE_DEPTH), .VALUE_LIMIT(VALUE_LIMIT)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_count (rsp_prime_count),
      .rsp_bounds_found(rsp_bounds_found),
      .sieve_busy      (sieve_busy)
   );

   // checks
   `SRPC_ASSERT(a_no_pop_in_sieve, clock, reset, !(sieve_busy && q_pop), "pop during sieve")
   `SRPC_ASSERT(a_no_rsp_in_sieve, clock, reset, !(sieve_busy && rsp_valid), "rsp during sieve")
   `SRPC_ASSERT(a_no_pop_when_rsp, clock, reset, !(rsp_valid && q_pop), "pop while rsp pending")
   `SRPC_ASSERT(a_rsp_holds, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "rsp dropped")

endmodule
